// File: rtl/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int COEF_WIDTH = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DISC_WIDTH = 34;
    localparam int ROOT_WIDTH = 34;
    localparam int NB_WIDTH   = 33;
    localparam int DEN_WIDTH  = 17;
    localparam int SQ_WIDTH   = 33;
    localparam int SQ_REM_W   = 37;
    localparam int SQ_INT     = 32;
    localparam int SQ_STEPS   = SQ_INT + FRAC_BITS;
    localparam int NUM_WIDTH  = 35;
    localparam int MAG_WIDTH  = 34;
    localparam int DIV_STEPS  = MAG_WIDTH;

    typedef enum logic [1:0] {
        ST_TWO  = 2'd0,
        ST_ONE  = 2'd1,
        ST_NONE = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef struct packed {
        t_status                       status;
        logic signed [DISC_WIDTH-1:0]  disc;
        logic signed [NB_WIDTH-1:0]    nb;
        logic signed [DEN_WIDTH-1:0]   den;
    } t_side;

endpackage

// File: rtl/qrs_front.sv
`timescale 1ns / 1ps
module qrs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0] i_coef_c,
    output logic                                 o_valid,
    output qrs_pkg::t_side                       o_side
);
    import qrs_pkg::*;

    logic                           r_v1;
    logic signed [2*COEF_WIDTH-1:0] r_bb;
    logic signed [2*COEF_WIDTH-1:0] r_ac;
    logic signed [COEF_WIDTH-1:0]   r_a;
    logic signed [COEF_WIDTH-1:0]   r_b;
    logic                           r_v2;
    t_side                          r_side;
    t_side                          n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb   <= i_coef_b * i_coef_b;
            r_ac   <= i_coef_a * i_coef_c;
            r_a    <= i_coef_a;
            r_b    <= i_coef_b;
            r_side <= n_side;
        end
    end

    always_comb begin
        n_side.disc = DISC_WIDTH'(r_bb) - (DISC_WIDTH'(r_ac) <<< 2);
        n_side.nb   = -(NB_WIDTH'(r_b) <<< FRAC_BITS);
        n_side.den  = DEN_WIDTH'(r_a) <<< 1;
        if (r_a == '0) begin
            n_side.status = ST_BAD;
        end else if (n_side.disc < 0) begin
            n_side.status = ST_NONE;
        end else if (n_side.disc == '0) begin
            n_side.status = ST_ONE;
        end else begin
            n_side.status = ST_TWO;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;
endmodule

// File: rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
module qrs_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  qrs_pkg::t_side                 i_side,
    output logic                           o_valid,
    output qrs_pkg::t_side                 o_side,
    output logic [qrs_pkg::SQ_WIDTH-1:0]   o_root
);
    import qrs_pkg::*;

    logic                r_v    [SQ_STEPS];
    logic [SQ_REM_W-1:0] r_rem  [SQ_STEPS];
    logic [SQ_WIDTH-1:0] r_root [SQ_STEPS];
    t_side               r_side [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic                v_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_WIDTH-1:0] root_in;
        t_side               side_in;
        logic [1:0]          pair;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                take;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        if (k < SQ_INT && 2 * (SQ_INT - 1 - k) + 1 < DISC_WIDTH) begin : g_pair
            assign pair = side_in.disc[2*(SQ_INT-1-k)+1 : 2*(SQ_INT-1-k)] &
                          {2{~side_in.disc[DISC_WIDTH-1]}};
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[SQ_REM_W-3:0], pair};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? rem_sh - trial : rem_sh;
                r_root[k] <= {root_in[SQ_WIDTH-2:0], take};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];
    assign o_root  = r_root[SQ_STEPS-1];
endmodule

// File: rtl/qrs_div.sv
`timescale 1ns / 1ps
module qrs_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  qrs_pkg::t_side                         i_side,
    input  logic [qrs_pkg::SQ_WIDTH-1:0]           i_root,
    output logic                                   o_valid,
    output qrs_pkg::t_status                       o_status,
    output logic signed [qrs_pkg::DISC_WIDTH-1:0]  o_disc,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  o_root_minus,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  o_root_plus
);
    import qrs_pkg::*;

    logic signed [NUM_WIDTH-1:0] num_m;
    logic signed [NUM_WIDTH-1:0] num_p;
    logic signed [NUM_WIDTH-1:0] abs_m;
    logic signed [NUM_WIDTH-1:0] abs_p;
    logic signed [DEN_WIDTH-1:0] abs_d;

    logic                 r_pv;
    logic [MAG_WIDTH-1:0] r_pm;
    logic [MAG_WIDTH-1:0] r_pp;
    logic                 r_negm;
    logic                 r_negp;
    logic [DEN_WIDTH-1:0] r_dmag;
    t_side                r_pside;

    assign num_m = NUM_WIDTH'(i_side.nb) - $signed({2'b00, i_root});
    assign num_p = NUM_WIDTH'(i_side.nb) + $signed({2'b00, i_root});
    assign abs_m = num_m[NUM_WIDTH-1] ? -num_m : num_m;
    assign abs_p = num_p[NUM_WIDTH-1] ? -num_p : num_p;
    assign abs_d = i_side.den[DEN_WIDTH-1] ? -i_side.den : i_side.den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm    <= abs_m[MAG_WIDTH-1:0];
            r_pp    <= abs_p[MAG_WIDTH-1:0];
            r_negm  <= num_m[NUM_WIDTH-1] ^ i_side.den[DEN_WIDTH-1];
            r_negp  <= num_p[NUM_WIDTH-1] ^ i_side.den[DEN_WIDTH-1];
            r_dmag  <= abs_d;
            r_pside <= i_side;
        end
    end

    logic                 r_v    [DIV_STEPS];
    logic [MAG_WIDTH-1:0] r_nm   [DIV_STEPS];
    logic [MAG_WIDTH-1:0] r_np   [DIV_STEPS];
    logic [MAG_WIDTH-1:0] r_qm   [DIV_STEPS];
    logic [MAG_WIDTH-1:0] r_qp   [DIV_STEPS];
    logic [DEN_WIDTH-1:0] r_rm   [DIV_STEPS];
    logic [DEN_WIDTH-1:0] r_rp   [DIV_STEPS];
    logic                 r_ngm  [DIV_STEPS];
    logic                 r_ngp  [DIV_STEPS];
    logic [DEN_WIDTH-1:0] r_dm   [DIV_STEPS];
    t_side                r_side [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                 v_in;
        logic [MAG_WIDTH-1:0] nm_in;
        logic [MAG_WIDTH-1:0] np_in;
        logic [MAG_WIDTH-1:0] qm_in;
        logic [MAG_WIDTH-1:0] qp_in;
        logic [DEN_WIDTH-1:0] rm_in;
        logic [DEN_WIDTH-1:0] rp_in;
        logic                 ngm_in;
        logic                 ngp_in;
        logic [DEN_WIDTH-1:0] dm_in;
        t_side                side_in;
        logic [DEN_WIDTH:0]   shm;
        logic [DEN_WIDTH:0]   shp;
        logic                 tm;
        logic                 tp;

        if (k == 0) begin : g_first
            assign v_in    = r_pv;
            assign nm_in   = r_pm;
            assign np_in   = r_pp;
            assign qm_in   = '0;
            assign qp_in   = '0;
            assign rm_in   = '0;
            assign rp_in   = '0;
            assign ngm_in  = r_negm;
            assign ngp_in  = r_negp;
            assign dm_in   = r_dmag;
            assign side_in = r_pside;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign nm_in   = r_nm[k-1];
            assign np_in   = r_np[k-1];
            assign qm_in   = r_qm[k-1];
            assign qp_in   = r_qp[k-1];
            assign rm_in   = r_rm[k-1];
            assign rp_in   = r_rp[k-1];
            assign ngm_in  = r_ngm[k-1];
            assign ngp_in  = r_ngp[k-1];
            assign dm_in   = r_dm[k-1];
            assign side_in = r_side[k-1];
        end

        assign shm = {rm_in, nm_in[MAG_WIDTH-1-k]};
        assign shp = {rp_in, np_in[MAG_WIDTH-1-k]};
        assign tm  = shm >= {1'b0, dm_in};
        assign tp  = shp >= {1'b0, dm_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nm[k]   <= nm_in;
                r_np[k]   <= np_in;
                r_qm[k]   <= {qm_in[MAG_WIDTH-2:0], tm};
                r_qp[k]   <= {qp_in[MAG_WIDTH-2:0], tp};
                r_rm[k]   <= DEN_WIDTH'(tm ? shm - {1'b0, dm_in} : shm);
                r_rp[k]   <= DEN_WIDTH'(tp ? shp - {1'b0, dm_in} : shp);
                r_ngm[k]  <= ngm_in;
                r_ngp[k]  <= ngp_in;
                r_dm[k]   <= dm_in;
                r_side[k] <= side_in;
            end
        end
    end

    localparam int L = DIV_STEPS - 1;

    logic                         r_ov;
    t_status                      r_status;
    logic signed [DISC_WIDTH-1:0] r_disc;
    logic signed [ROOT_WIDTH-1:0] r_rmn;
    logic signed [ROOT_WIDTH-1:0] r_rpl;
    logic [ROOT_WIDTH-1:0]        qm_s;
    logic [ROOT_WIDTH-1:0]        qp_s;

    assign qm_s = r_ngm[L] ? -r_qm[L] : r_qm[L];
    assign qp_s = r_ngp[L] ? -r_qp[L] : r_qp[L];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status <= r_side[L].status;
            r_disc   <= r_side[L].disc;
            r_rmn    <= (r_side[L].status == ST_TWO || r_side[L].status == ST_ONE) ?
                        $signed(qm_s) : '0;
            r_rpl    <= (r_side[L].status == ST_TWO) ? $signed(qp_s) : '0;
        end
    end

    assign o_valid      = r_ov;
    assign o_status     = r_status;
    assign o_disc       = r_disc;
    assign o_root_minus = r_rmn;
    assign o_root_plus  = r_rpl;
endmodule

// File: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Solves a*x^2 + b*x + c = 0 for one coefficient set per request and returns the exact
// discriminant, a status and the real roots in signed Q17.16. A new request is taken in
// every clock cycle while the result side keeps up, and each result passes through the
// product and discriminant registers, the bit-per-stage square root, a magnitude register,
// the two parallel bit-per-stage dividers and the output register. The whole pipeline holds
// when a result is waiting and not taken.
module quadratic_root_solver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // coef_a, coef_b, coef_c
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // discriminant, root_minus, root_plus, zero pad
    output logic [1:0]   m_axis_tuser   // status
);
    import qrs_pkg::*;

    logic                         en;
    logic                         f_valid;
    t_side                        f_side;
    logic                         s_valid;
    t_side                        s_side;
    logic [SQ_WIDTH-1:0]          s_root;
    t_status                      d_status;
    logic signed [DISC_WIDTH-1:0] d_disc;
    logic signed [ROOT_WIDTH-1:0] d_rm;
    logic signed [ROOT_WIDTH-1:0] d_rp;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_coef_a (s_axis_tdata[15:0]),
        .i_coef_b (s_axis_tdata[31:16]),
        .i_coef_c (s_axis_tdata[47:32]),
        .o_valid  (f_valid),
        .o_side   (f_side)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_side  (s_side),
        .o_root  (s_root)
    );

    qrs_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s_valid),
        .i_side       (s_side),
        .i_root       (s_root),
        .o_valid      (m_axis_tvalid),
        .o_status     (d_status),
        .o_disc       (d_disc),
        .o_root_minus (d_rm),
        .o_root_plus  (d_rp)
    );

    assign m_axis_tuser = d_status;
    assign m_axis_tdata = {2'b00, d_rp, d_rm, d_disc};
endmodule

// File: rtl/qrs_checker.sv
`timescale 1ns / 1ps
module qrs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    import qrs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_BAD || m_axis_tuser == ST_NONE)
        |-> m_axis_tdata[101:34] == '0)
        else $error("Roots not zero without real roots.");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_ONE
        |-> m_axis_tdata[33:0] == '0 && m_axis_tdata[101:68] == '0)
        else $error("Repeated root with nonzero discriminant or second root.");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_TWO || m_axis_tuser == ST_NONE)
        |-> m_axis_tdata[33] == (m_axis_tuser == ST_NONE))
        else $error("Status disagrees with discriminant sign.");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
